@@ hdl/counter_wait_table_top_assert.svh @@
// ----------------------------------------------------------------------------
// counter wait table assertion macros
// concurrent checks on aclk; CWT_ASSERT is quiet while aresetn is low
// ----------------------------------------------------------------------------
`ifndef COUNTER_WAIT_TABLE_TOP_ASSERT_SVH
`define COUNTER_WAIT_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define CWT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define CWT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define CWT_ASSERT(lbl, prop, msg)
`define CWT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hdl/cwt_pkg.sv @@
// ----------------------------------------------------------------------------
// cwt_pkg
// shared widths, codes, state type and cell control bundle
// ----------------------------------------------------------------------------
package cwt_pkg;

    localparam int unsigned WAIT_SLOTS_DEF = 16;
    localparam int unsigned COUNT_W        = 32;
    localparam int unsigned TAG_W          = 32;
    localparam int unsigned PIN_W          = 8;
    localparam int unsigned SLOTS_W        = 5;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned CFG_DATA_W     = 32;

    localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RST = SLOTS_W'(16);
    localparam logic [COUNT_W-1:0] INITIAL_COUNT_RST = '0;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_READY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_WAKE   = 2'd3;

    // item kinds
    localparam logic KIND_ADD_WAIT  = 1'b0;
    localparam logic KIND_SET_VALUE = 1'b1;

    // register indexes
    localparam logic REG_SLOTS_IN_USE  = 1'b0;
    localparam logic REG_INITIAL_COUNT = 1'b1;

    typedef enum logic {
        CWT_IDLE,
        CWT_SCAN
    } cwt_state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic advance;   // token moves one cell up
        logic clear;     // token removed from the chain
        logic claim;     // token cell takes the waiter
        logic vacate;    // token cell frees its slot
    } cell_ctrl_t;

endpackage

@@ hdl/counter_wait_table_top.sv @@
// ----------------------------------------------------------------------------
// counter_wait_table_top
// waiter table of a task counter, built as a chain of slot cells
// ----------------------------------------------------------------------------
//  channel  | handshake         | beat contents
//  ---------+-------------------+------------------------------------------------
//  cfg      | cfg_we            | cfg_index, cfg_wdata
//  s_       | s_valid / s_ready | kind, waiter_tag, target_count, thread_pin,
//           |                   | new_count
//  m_       | m_valid / m_ready | status, woken_tag, woken_thread, last
//
//  one item at a time: a token enters cell 0 on acceptance and climbs one cell
//  per cycle while the output can take a beat; an add_wait scan ends at the first
//  free slot below slots_in_use, or at that limit, and a set_value scan at its
//  highest matching slot (at once with no match); either kind is held up while
//  m_ready holds a waiting beat back.
//  the token only moves while the output register is empty or being drained.
//  reset (aresetn low, synchronous) frees every slot, sets slots_in_use to 16
//  and the counter to 0; slot contents are not cleared.
// ----------------------------------------------------------------------------
module counter_wait_table_top #(
    parameter int unsigned WAIT_SLOTS = cwt_pkg::WAIT_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [cwt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [cwt_pkg::TAG_W-1:0]       s_waiter_tag,
    input  logic [cwt_pkg::COUNT_W-1:0]     s_target_count,
    input  logic [cwt_pkg::PIN_W-1:0]       s_thread_pin,
    input  logic [cwt_pkg::COUNT_W-1:0]     s_new_count,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cwt_pkg::STATUS_W-1:0]    m_status,
    output logic [cwt_pkg::TAG_W-1:0]       m_woken_tag,
    output logic [cwt_pkg::PIN_W-1:0]       m_woken_thread,
    output logic                            m_last
);
    import cwt_pkg::*;
    `include "counter_wait_table_top_assert.svh"

    // control and item registers
    cwt_state_t          state_reg, state_next;
    logic                kind_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [COUNT_W-1:0]  target_reg;
    logic [PIN_W-1:0]    pin_reg;
    logic [COUNT_W-1:0]  current_count_reg;
    logic [SLOTS_W-1:0]  slots_in_use_reg;
    logic                off_end_reg;

    // output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [TAG_W-1:0]    m_tag_reg;
    logic [PIN_W-1:0]    m_thread_reg;
    logic                m_last_reg;

    // chain status
    logic [WAIT_SLOTS-1:0] tok_vec;
    logic [WAIT_SLOTS-1:0] tok_in;
    logic [WAIT_SLOTS-1:0] busy_vec;
    logic [WAIT_SLOTS-1:0] match_vec;
    logic [WAIT_SLOTS-1:0] range_vec;
    logic [TAG_W-1:0]      cell_tag    [WAIT_SLOTS];
    logic [PIN_W-1:0]      cell_thread [WAIT_SLOTS];

    // decisions of the scan step
    logic                s_accept;
    logic                step_en;
    logic                at_free;
    logic                at_out;
    logic                hit;
    logic                rest;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_last;
    logic                claim_slot;
    logic                release_slot;
    logic                step_advance;
    logic                scan_done;
    logic [TAG_W-1:0]    tok_tag;
    logic [PIN_W-1:0]    tok_thread;
    cell_ctrl_t          cell_ctrl;

    assign s_accept = s_valid && s_ready;
    // the token may act only if its beat, if any, has somewhere to go
    assign step_en  = (state_reg == CWT_SCAN) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // the cell chain: cell 0 takes the token on acceptance
    // ------------------------------------------------------------------
    assign tok_in[0] = s_accept;

    for (genvar g = 0; g < WAIT_SLOTS; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign tok_in[g] = tok_vec[g-1];
        end
        // slots at or above slots_in_use are out of reach
        assign range_vec[g] = (32'(g) < 32'(slots_in_use_reg));

        cwt_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (cell_ctrl),
            .token_in     (tok_in[g]),
            .count_val    (current_count_reg),
            .claim_target (target_reg),
            .claim_tag    (tag_reg),
            .claim_pin    (pin_reg),
            .token_out    (tok_vec[g]),
            .busy         (busy_vec[g]),
            .match        (match_vec[g]),
            .slot_tag     (cell_tag[g]),
            .slot_thread  (cell_thread[g])
        );
    end

    // contents of the cell that holds the token (one-hot select)
    always_comb begin
        tok_tag    = '0;
        tok_thread = '0;
        for (int i = 0; i < WAIT_SLOTS; i++) begin
            if (tok_vec[i]) begin
                tok_tag    = tok_tag | cell_tag[i];
                tok_thread = tok_thread | cell_thread[i];
            end
        end
    end

    // token position against the table
    assign at_free = |(tok_vec & ~busy_vec & range_vec);
    assign at_out  = (|(tok_vec & ~range_vec)) || off_end_reg;
    assign hit     = |(tok_vec & match_vec & range_vec);
    // matches still waiting above the token; lower ones are already freed
    assign rest    = |(match_vec & range_vec & ~tok_vec);

    // ------------------------------------------------------------------
    // scan step decision
    // ------------------------------------------------------------------
    always_comb begin
        emit         = 1'b0;
        emit_status  = ST_QUEUED;
        emit_last    = 1'b1;
        claim_slot   = 1'b0;
        release_slot = 1'b0;
        step_advance = 1'b0;
        scan_done    = 1'b0;
        if (step_en) begin
            case (kind_reg)
                KIND_ADD_WAIT: begin
                    if (at_out) begin
                        // no free slot below the limit: fullness wins
                        emit        = 1'b1;
                        emit_status = ST_FULL;
                        scan_done   = 1'b1;
                    end else if (at_free) begin
                        emit      = 1'b1;
                        scan_done = 1'b1;
                        if (target_reg == current_count_reg) begin
                            emit_status = ST_READY;
                        end else begin
                            emit_status = ST_QUEUED;
                            claim_slot  = 1'b1;
                        end
                    end else begin
                        step_advance = 1'b1;
                    end
                end
                KIND_SET_VALUE: begin
                    if (hit) begin
                        emit         = 1'b1;
                        emit_status  = ST_WAKE;
                        emit_last    = !rest;
                        release_slot = 1'b1;
                        scan_done    = !rest;
                        step_advance = rest;
                    end else if (!rest) begin
                        // nothing left to wake
                        scan_done = 1'b1;
                    end else begin
                        step_advance = 1'b1;
                    end
                end
                default: begin
                    scan_done = 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CWT_IDLE: begin
                if (s_valid) begin
                    state_next = CWT_SCAN;
                end
            end
            CWT_SCAN: begin
                if (scan_done) begin
                    state_next = CWT_IDLE;
                end
            end
            default: begin
                state_next = CWT_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready           = (state_reg == CWT_IDLE);
        cell_ctrl.advance = s_accept || step_advance;
        cell_ctrl.clear   = scan_done;
        cell_ctrl.claim   = claim_slot;
        cell_ctrl.vacate  = release_slot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CWT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // configuration and counter
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg  <= SLOTS_IN_USE_RST;
            current_count_reg <= INITIAL_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SLOTS_IN_USE:  slots_in_use_reg  <= cfg_wdata[SLOTS_W-1:0];
                REG_INITIAL_COUNT: current_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end else if (s_accept && (s_kind == KIND_SET_VALUE)) begin
            current_count_reg <= s_new_count;
        end
    end

    // item held for the scan
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg   <= s_kind;
            tag_reg    <= s_waiter_tag;
            target_reg <= s_target_count;
            pin_reg    <= s_thread_pin;
        end
    end

    // token fell off the top of the chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_end_reg <= 1'b0;
        end else if (cell_ctrl.advance) begin
            off_end_reg <= tok_vec[WAIT_SLOTS-1];
        end else if (cell_ctrl.clear) begin
            off_end_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg <= emit_status;
            m_last_reg   <= emit_last;
            if (emit_status == ST_WAKE) begin
                m_tag_reg    <= tok_tag;
                m_thread_reg <= tok_thread;
            end else begin
                m_tag_reg    <= '0;
                m_thread_reg <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_woken_tag    = m_tag_reg;
    assign m_woken_thread = m_thread_reg;
    assign m_last         = m_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CWT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_valid_reg && !off_end_reg), "busy after reset")
    `CWT_ASSERT(a_one_token, $onehot0(tok_vec), "more than one scan token")
    `CWT_ASSERT(a_idle_no_token, (state_reg == CWT_IDLE) |-> (tok_vec == '0), "stray token")
    `CWT_ASSERT(a_release_on_match, release_slot |-> hit, "slot freed without a match")
    `CWT_ASSERT(a_claim_free, claim_slot |-> (at_free && !at_out), "claim of a busy slot")
    `CWT_ASSERT(a_wake_goes_on, !emit_last |=> (state_reg == CWT_SCAN), "scan ended early")

endmodule

@@ hdl/cwt_cell.sv @@
// ----------------------------------------------------------------------------
// cwt_cell
// one waiter slot with its share of the scan token chain
// ----------------------------------------------------------------------------
module cwt_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cwt_pkg::cell_ctrl_t          ctrl,
    input  logic                         token_in,
    input  logic [cwt_pkg::COUNT_W-1:0]  count_val,
    input  logic [cwt_pkg::COUNT_W-1:0]  claim_target,
    input  logic [cwt_pkg::TAG_W-1:0]    claim_tag,
    input  logic [cwt_pkg::PIN_W-1:0]    claim_pin,
    output logic                         token_out,
    output logic                         busy,
    output logic                         match,
    output logic [cwt_pkg::TAG_W-1:0]    slot_tag,
    output logic [cwt_pkg::PIN_W-1:0]    slot_thread
);
    import cwt_pkg::*;

    logic               token_reg;
    logic               busy_reg;
    logic [COUNT_W-1:0] target_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [PIN_W-1:0]   thread_reg;

    // token hop and slot occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                token_reg <= 1'b0;
            end else if (ctrl.advance) begin
                token_reg <= token_in;
            end
            if (ctrl.claim && token_reg) begin
                busy_reg <= 1'b1;
            end else if (ctrl.vacate && token_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // slot contents
    always_ff @(posedge aclk) begin
        if (ctrl.claim && token_reg) begin
            target_reg <= claim_target;
            tag_reg    <= claim_tag;
            thread_reg <= claim_pin;
        end
    end

    assign token_out   = token_reg;
    assign busy        = busy_reg;
    assign match       = busy_reg && (target_reg == count_val);
    assign slot_tag    = tag_reg;
    assign slot_thread = thread_reg;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the counter wait table: a directed walk through
// slot limits, full table and unchanged-value cases, then random phases with
// a small pool of target values so waiters queue, fill the table and wake in
// groups; every result beat is compared against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_top;

    import cwt_pkg::*;

    localparam int unsigned SLOTS = WAIT_SLOTS_DEF;
    // longest internal walk of one item, used before register writes and at the end
    localparam int unsigned SETTLE_CYCLES = SLOTS + 8;

    // one expected or observed result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [PIN_W-1:0]    thread;
        logic                last;
    } wait_result_t;

    // one row of the directed walk: an input beat or a register write
    typedef enum logic {
        STEP_BEAT,
        STEP_REG
    } step_kind_t;

    typedef struct {
        step_kind_t          what;
        logic                reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                kind;
        logic [TAG_W-1:0]    tag;
        logic [COUNT_W-1:0]  target;
        logic [PIN_W-1:0]    pin;
        logic [COUNT_W-1:0]  value;
        bit                  typed;        // expected status written in the row
        logic [STATUS_W-1:0] typed_status;
    } step_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [TAG_W-1:0]      s_waiter_tag;
    logic [COUNT_W-1:0]    s_target_count;
    logic [PIN_W-1:0]      s_thread_pin;
    logic [COUNT_W-1:0]    s_new_count;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [TAG_W-1:0]      m_woken_tag;
    logic [PIN_W-1:0]      m_woken_thread;
    logic                  m_last;

    counter_wait_table_top #(
        .WAIT_SLOTS(SLOTS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_waiter_tag   (s_waiter_tag),
        .s_target_count (s_target_count),
        .s_thread_pin   (s_thread_pin),
        .s_new_count    (s_new_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_woken_tag    (m_woken_tag),
        .m_woken_thread (m_woken_thread),
        .m_last         (m_last)
    );

    // ------------------------------------------------------------------------
    // predictor state: its own copy of the slots, the counter and the registers
    // ------------------------------------------------------------------------
    logic               pred_busy   [SLOTS];
    logic [COUNT_W-1:0] pred_target [SLOTS];
    logic [TAG_W-1:0]   pred_tag    [SLOTS];
    logic [PIN_W-1:0]   pred_pin    [SLOTS];
    logic [COUNT_W-1:0] pred_count;
    logic [SLOTS_W-1:0] pred_slots_reg;
    logic [COUNT_W-1:0] pred_init_reg;

    // results still to come, oldest first
    wait_result_t pending_results[$];

    int errors;
    int beats_in;
    int beats_out;
    int seen_status [4];
    int reg_writes;

    step_t directed_steps[$];

    // clock, 20 ns period
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard limit on run length, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic step_t beat_row(logic kind, logic [TAG_W-1:0] tag,
                                       logic [COUNT_W-1:0] target, logic [PIN_W-1:0] pin,
                                       logic [COUNT_W-1:0] value, bit typed,
                                       logic [STATUS_W-1:0] status);
        step_t s;
        s.what         = STEP_BEAT;
        s.reg_idx      = REG_SLOTS_IN_USE;
        s.reg_data     = '0;
        s.kind         = kind;
        s.tag          = tag;
        s.target       = target;
        s.pin          = pin;
        s.value        = value;
        s.typed        = typed;
        s.typed_status = status;
        return s;
    endfunction

    function automatic step_t reg_row(logic idx, logic [CFG_DATA_W-1:0] data);
        step_t s;
        s = beat_row(KIND_ADD_WAIT, '0, '0, '0, '0, 1'b0, ST_QUEUED);
        s.what     = STEP_REG;
        s.reg_idx  = idx;
        s.reg_data = data;
        return s;
    endfunction

    task automatic reset_prediction();
        for (int i = 0; i < SLOTS; i++) begin
            pred_busy[i]   = 1'b0;
            pred_target[i] = '0;
            pred_tag[i]    = '0;
            pred_pin[i]    = '0;
        end
        pred_slots_reg = SLOTS_IN_USE_RST;
        pred_init_reg  = INITIAL_COUNT_RST;
        pred_count     = INITIAL_COUNT_RST;
    endtask

    // works out the results of one accepted beat and queues them
    task automatic predict_wait_table(input logic kind, input logic [TAG_W-1:0] tag,
                                      input logic [COUNT_W-1:0] target,
                                      input logic [PIN_W-1:0] pin,
                                      input logic [COUNT_W-1:0] value);
        int           n;
        int           free_idx;
        bit           woke;
        wait_result_t r;
        // register values above the built depth saturate
        n        = (pred_slots_reg > SLOTS) ? SLOTS : int'(pred_slots_reg);
        free_idx = -1;
        woke     = 1'b0;
        r        = '0;
        if (kind == KIND_ADD_WAIT) begin
            for (int i = n - 1; i >= 0; i--) begin
                if (!pred_busy[i]) free_idx = i;
            end
            r.last = 1'b1;
            // fullness wins over a met target
            if (free_idx < 0) begin
                r.status = ST_FULL;
            end else if (target == pred_count) begin
                r.status = ST_READY;
            end else begin
                pred_busy[free_idx]   = 1'b1;
                pred_target[free_idx] = target;
                pred_tag[free_idx]    = tag;
                pred_pin[free_idx]    = pin;
                r.status              = ST_QUEUED;
            end
            pending_results.push_back(r);
        end else begin
            pred_count = value;
            for (int i = 0; i < n; i++) begin
                if (pred_busy[i] && pred_target[i] == value) begin
                    pred_busy[i] = 1'b0;
                    r.status     = ST_WAKE;
                    r.tag        = pred_tag[i];
                    r.thread     = pred_pin[i];
                    r.last       = 1'b0;
                    pending_results.push_back(r);
                    woke = 1'b1;
                end
            end
            if (woke) pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endtask

    // one input beat: optional gap with valid low, then hold until accepted
    task automatic send_beat(input logic kind, input logic [TAG_W-1:0] tag,
                             input logic [COUNT_W-1:0] target, input logic [PIN_W-1:0] pin,
                             input logic [COUNT_W-1:0] value, input int gap,
                             input bit typed, input logic [STATUS_W-1:0] typed_status);
        wait_result_t r;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_waiter_tag   <= tag;
        s_target_count <= target;
        s_thread_pin   <= pin;
        s_new_count    <= value;
        do @(posedge aclk); while (!s_ready);
        beats_in++;
        predict_wait_table(kind, tag, target, pin, value);
        // rows with a hand-written status replace the single predicted beat
        if (typed) begin
            r        = '0;
            r.status = typed_status;
            r.last   = 1'b1;
            pending_results[pending_results.size() - 1] = r;
        end
    endtask

    // drop valid on the edge after the last acceptance and wait for every result
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // register write, only once the block has gone quiet
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        // a set_value without matches may still be scanning
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == REG_SLOTS_IN_USE) begin
            pred_slots_reg = data[SLOTS_W-1:0];
        end else begin
            pred_init_reg = data[COUNT_W-1:0];
            pred_count    = data[COUNT_W-1:0];
        end
        reg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls per beat, with calm stretches of no stall
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int           stall_left;
        int           calm_left;
        wait_result_t want;
        stall_left = 0;
        calm_left  = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= (stall_left == 0);
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                beats_out++;
                seen_status[m_status]++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, status %0h tag %0h thread %0h",
                             $time, m_status, m_woken_tag, m_woken_thread);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_status));
                    compare_field("woken_tag", want.tag, m_woken_tag);
                    compare_field("woken_thread", 32'(want.thread), 32'(m_woken_thread));
                    compare_field("last", 32'(want.last), 32'(m_last));
                end
                if (calm_left > 0) begin
                    calm_left--;
                    stall_left = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    calm_left  = $urandom_range(8, 40);
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 4);
                end
            end else if (m_valid && stall_left > 0) begin
                stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                   phase_slots [8];
        logic [COUNT_W-1:0]   phase_init  [8];
        logic [COUNT_W-1:0]   pool        [4];
        int                   phase_items;
        int                   gap;
        int                   pick;
        bit                   calm_send;
        logic                 kind;
        logic [TAG_W-1:0]     tag;
        logic [COUNT_W-1:0]   target;
        logic [PIN_W-1:0]     pin;
        logic [COUNT_W-1:0]   value;
        step_t                s;

        // every input known from time zero, reset held low
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SLOTS_IN_USE;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_kind         = KIND_ADD_WAIT;
        s_waiter_tag   = '0;
        s_target_count = '0;
        s_thread_pin   = '0;
        s_new_count    = '0;
        errors         = 0;
        beats_in       = 0;
        beats_out      = 0;
        reg_writes     = 0;
        for (int i = 0; i < 4; i++) seen_status[i] = 0;
        reset_prediction();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed walk: typed status where the answer is plain after reset
        // counter is 0 after reset, so a target of 0 is met at once
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, '0, '0, '0, '0, 1, ST_READY));
        // all-ones waiter into slot 0, a second into slot 1
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, '1, '1, '1, '0, 1, ST_QUEUED));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'h1234_5678, 32'd5, 8'd7, '0,
                                          1, ST_QUEUED));
        directed_steps.push_back(beat_row(KIND_SET_VALUE, '0, '0, '0, 32'd5, 0, ST_WAKE));
        directed_steps.push_back(beat_row(KIND_SET_VALUE, '0, '0, '0, '1, 0, ST_WAKE));
        // no match, no beat
        directed_steps.push_back(beat_row(KIND_SET_VALUE, '0, '0, '0, '0, 0, ST_WAKE));
        // waiter whose target becomes the counter through the register, then
        // a set_value with the unchanged value still wakes it
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'hCAFE_0009, 32'd9, 8'd3, '0,
                                          1, ST_QUEUED));
        directed_steps.push_back(reg_row(REG_INITIAL_COUNT, 32'd9));
        directed_steps.push_back(beat_row(KIND_SET_VALUE, '0, '0, '0, 32'd9, 0, ST_WAKE));
        // one slot: later waiters find the table full, even one with its target met
        directed_steps.push_back(reg_row(REG_SLOTS_IN_USE, 32'd1));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'h0BAD_0003, 32'd3, 8'd255, '0,
                                          1, ST_QUEUED));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'h0BAD_0004, 32'd4, 8'd1, '0,
                                          1, ST_FULL));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'h0BAD_0009, 32'd9, 8'd2, '0,
                                          1, ST_FULL));
        // zero slots: nothing fits, and slot 0 above the limit is left alone
        directed_steps.push_back(reg_row(REG_SLOTS_IN_USE, 32'd0));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'h0BAD_0005, 32'd4, 8'd5, '0,
                                          1, ST_FULL));
        directed_steps.push_back(beat_row(KIND_SET_VALUE, '0, '0, '0, 32'd3, 0, ST_WAKE));
        // limit of 31 saturates to the built depth, slot 0 comes back into view
        directed_steps.push_back(reg_row(REG_SLOTS_IN_USE, 32'hFFFF_FFFF));
        directed_steps.push_back(beat_row(KIND_SET_VALUE, '0, '0, '0, 32'd3, 0, ST_WAKE));
        // three waiters on one value wake in slot order
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'hA000_0001, 32'd8, 8'd10, '0,
                                          1, ST_QUEUED));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'hA000_0002, 32'd8, 8'd20, '0,
                                          1, ST_QUEUED));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'hA000_0003, 32'd8, 8'd30, '0,
                                          1, ST_QUEUED));
        directed_steps.push_back(beat_row(KIND_SET_VALUE, '0, '0, '0, 32'd8, 0, ST_WAKE));
        // top counter value met at once
        directed_steps.push_back(reg_row(REG_INITIAL_COUNT, 32'hFFFF_FFFF));
        directed_steps.push_back(beat_row(KIND_ADD_WAIT, 32'h5555_AAAA, '1, 8'd0, '0,
                                          1, ST_READY));

        foreach (directed_steps[k]) begin
            s = directed_steps[k];
            if (s.what == STEP_REG) begin
                write_reg(s.reg_idx, s.reg_data);
            end else begin
                send_beat(s.kind, s.tag, s.target, s.pin, s.value, $urandom_range(0, 4),
                          s.typed, s.typed_status);
            end
        end

        // random phases, each with its own slot limit and start value
        phase_slots = '{16, 1, 4, 31, 0, 8, 16, 0};
        phase_slots[7] = $urandom_range(0, 31);
        phase_init  = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        for (int p = 2; p < 8; p++) phase_init[p] = $urandom;
        phase_init[4] = 32'h0;

        for (int p = 0; p < 8; p++) begin
            // upper data bits of the limit write carry noise
            write_reg(REG_SLOTS_IN_USE,
                      ($urandom & ~32'(5'h1F)) | 32'(phase_slots[p]));
            write_reg(REG_INITIAL_COUNT, phase_init[p]);

            // small pool so targets collide; init+1 wraps on the all-ones phase
            pool[0] = phase_init[p];
            pool[1] = $urandom;
            pool[2] = $urandom;
            pool[3] = phase_init[p] + 1;

            calm_send   = (p % 3 == 2);
            phase_items = (phase_slots[p] == 0) ? 16 : 64;

            for (int n = 0; n < phase_items; n++) begin
                // sender holds off once mid-phase until the table is quiet
                if (n == phase_items / 2) drain_results();
                pick   = $urandom_range(0, 99);
                tag    = $urandom;
                pin    = ($urandom_range(0, 7) == 0) ? 8'd255 : PIN_W'($urandom);
                target = pool[$urandom_range(0, 3)];
                value  = pool[$urandom_range(0, 3)];
                if (pick < 8) begin
                    // noise: any kind, any values
                    kind   = logic'($urandom_range(0, 1));
                    target = $urandom;
                    value  = $urandom;
                end else if (pick < 36) begin
                    kind = KIND_SET_VALUE;
                    if ($urandom_range(0, 9) == 0) value = $urandom;
                end else begin
                    kind = KIND_ADD_WAIT;
                end
                gap = calm_send ? 0 : $urandom_range(0, 4);
                send_beat(kind, tag, target, pin, value, gap, 1'b0, ST_QUEUED);
            end
        end

        // wind down: all results in, then a quiet stretch for stray beats
        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);

        $display("run: %0d beats in, %0d results out over %0d register writes",
                 beats_in, beats_out, reg_writes);
        $display("results by status: queued %0d, ready_now %0d, table_full %0d, wake %0d",
                 seen_status[ST_QUEUED], seen_status[ST_READY], seen_status[ST_FULL],
                 seen_status[ST_WAKE]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
